// ----- src/swfs_pkg.sv -----
`timescale 1ns / 1ps
package swfs_pkg;

   localparam int MAX_DIM     = 64;
   localparam int MAX_WINDOW  = 1024;
   localparam int SAMPLE_BITS = 16;

   localparam int DIM_W   = $clog2(MAX_DIM);
   localparam int SLOT_W  = $clog2(MAX_WINDOW);
   localparam int FRAME_W = SLOT_W + 1;
   localparam int COUNT_W = SLOT_W + 1;
   localparam int HIST_AW = SLOT_W + DIM_W;
   localparam int PROD_W  = 2 * SAMPLE_BITS;
   localparam int SUM_W   = 26;
   localparam int SQ_W    = 41;

   localparam int WIN_W  = 11;
   localparam int FD_W   = 7;
   localparam int CSR_W  = 11;
   localparam int CSR_AW = 1;

   localparam logic [CSR_AW-1:0] CSR_WINDOW_LEN = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_FEAT_DIM   = 1'b1;

   localparam logic [WIN_W-1:0] WIN_RESET = 11'd600;
   localparam logic [FD_W-1:0]  DIM_RESET = 7'd40;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   typedef struct packed {
      logic [WIN_W-1:0] window_len;
      logic [FD_W-1:0]  feat_dim;
   } swfs_cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x;
      logic                          start;
      logic [DIM_W-1:0]              d;
      logic                          last;
      logic                          sub;
      logic [HIST_AW-1:0]            rd_addr;
      logic [HIST_AW-1:0]            wr_addr;
      logic [COUNT_W-1:0]            frames;
   } swfs_item_type;

endpackage

// ----- src/swfs_front.sv -----
`timescale 1ns / 1ps
module swfs_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swfs_pkg::swfs_cfg_type               cfg,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [swfs_pkg::SAMPLE_BITS-1:0] req_feature_value,
   input  logic                                 req_start_of_stream,
   input  logic                                 q_full,
   output logic                                 q_push,
   output swfs_pkg::swfs_item_type              q_item
);
   import swfs_pkg::*;

   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [DIM_W-1:0]   elem_ff, elem_in;
   logic [WIN_W-1:0]   win;
   logic [FD_W-1:0]    dim;
   logic [FRAME_W-1:0] t;
   logic [DIM_W-1:0]   e, d, dmax;
   logic [FRAME_W:0]   t_plus, t_wrap;
   logic [SLOT_W-1:0]  old_slot;
   logic               last;

   always_comb begin
      win = cfg.window_len;
      if (cfg.window_len == '0) begin
         win = WIN_W'(1);
      end else if (cfg.window_len > WIN_W'(MAX_WINDOW)) begin
         win = WIN_W'(MAX_WINDOW);
      end
      dim = cfg.feat_dim;
      if (cfg.feat_dim == '0) begin
         dim = FD_W'(1);
      end else if (cfg.feat_dim > FD_W'(MAX_DIM)) begin
         dim = FD_W'(MAX_DIM);
      end
      dmax = DIM_W'(dim - FD_W'(1));
      t    = req_start_of_stream ? '0 : frame_ff;
      e    = req_start_of_stream ? '0 : elem_ff;
      d    = (FD_W'(e) >= dim) ? dmax : e;
      last = (d == dmax);
      t_plus   = (FRAME_W + 1)'(t) + (FRAME_W + 1)'(1);
      t_wrap   = (t_plus >= (FRAME_W + 1)'(2 * MAX_WINDOW)) ?
                 t_plus - (FRAME_W + 1)'(MAX_WINDOW) : t_plus;
      old_slot = SLOT_W'(t) - SLOT_W'(win);

      q_item.x       = req_feature_value;
      q_item.start   = req_start_of_stream;
      q_item.d       = d;
      q_item.last    = last;
      q_item.sub     = ((FRAME_W + 1)'(t) >= (FRAME_W + 1)'(win));
      q_item.rd_addr = {old_slot, d};
      q_item.wr_addr = {t[SLOT_W-1:0], d};
      q_item.frames  = (t_plus < (FRAME_W + 1)'(win)) ? COUNT_W'(t_plus) : COUNT_W'(win);

      frame_in = last ? FRAME_W'(t_wrap) : t;
      elem_in  = last ? '0 : DIM_W'(d + DIM_W'(1));
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         elem_ff  <= '0;
      end else if (q_push) begin
         frame_ff <= frame_in;
         elem_ff  <= elem_in;
      end
   end

endmodule

// ----- src/swfs_queue.sv -----
`timescale 1ns / 1ps
module swfs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  swfs_pkg::swfs_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    out_valid,
   output swfs_pkg::swfs_item_type out_item
);
   import swfs_pkg::*;

   swfs_item_type     slots [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_AW:0]     count_ff;
   logic              do_pop;

   assign full      = (count_ff == (Q_AW + 1)'(Q_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slots[rd_ptr_ff];
   assign do_pop    = pop && out_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= Q_AW'(wr_ptr_ff + Q_AW'(1));
         end
         if (do_pop) begin
            rd_ptr_ff <= Q_AW'(rd_ptr_ff + Q_AW'(1));
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + (Q_AW + 1)'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - (Q_AW + 1)'(1);
         end
      end
   end

endmodule

// ----- src/swfs_back.sv -----
`timescale 1ns / 1ps
module swfs_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  swfs_pkg::swfs_item_type              in_item,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [swfs_pkg::SUM_W-1:0]    rsp_window_sum,
   output logic [swfs_pkg::SQ_W-1:0]            rsp_window_square_sum,
   output logic [swfs_pkg::COUNT_W-1:0]         rsp_frames_in_window,
   output logic [swfs_pkg::DIM_W-1:0]           rsp_dim_index,
   output logic                                 rsp_last_of_frame
);
   import swfs_pkg::*;

   logic [SAMPLE_BITS-1:0] hist_mem [2**HIST_AW];
   logic [SUM_W-1:0]       sum_mem  [MAX_DIM];
   logic [SQ_W-1:0]        sq_mem   [MAX_DIM];
   logic [MAX_DIM-1:0]     sum_vld_ff;

   // stage 1: history read and write, square of the new sample
   logic                          r1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] r1_x_ff;
   logic                          r1_start_ff, r1_last_ff, r1_sub_ff;
   logic [DIM_W-1:0]              r1_d_ff;
   logic [COUNT_W-1:0]            r1_frames_ff;
   logic [PROD_W-1:0]             r1_xsq_ff;
   logic [SAMPLE_BITS-1:0]        hist_rd_ff;
   logic signed [PROD_W-1:0]      xsq_full;

   // stage 2: square of the leaving sample, sums read
   logic                          r2_valid_ff;
   logic signed [SAMPLE_BITS-1:0] r2_x_ff, r2_y_ff;
   logic                          r2_start_ff, r2_last_ff;
   logic [DIM_W-1:0]              r2_d_ff;
   logic [COUNT_W-1:0]            r2_frames_ff;
   logic [PROD_W-1:0]             r2_xsq_ff, r2_ysq_ff;
   logic [SUM_W-1:0]              sum_rd_ff, fwd_sum_ff;
   logic [SQ_W-1:0]               sq_rd_ff, fwd_sq_ff;
   logic                          fwd_ff, zero_ff;
   logic signed [SAMPLE_BITS-1:0] y_val, y_eff;
   logic signed [PROD_W-1:0]      ysq_full;

   logic                          rsp_valid_ff;
   logic [SUM_W-1:0]              old_sum, new_sum;
   logic [SQ_W-1:0]               old_sq, new_sq;
   logic                          adv_out, adv_r2;
   logic                          fwd_in, zero_in;

   assign adv_out = r2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign adv_r2  = r1_valid_ff && (!r2_valid_ff || adv_out);
   assign pop     = in_valid && (!r1_valid_ff || adv_r2);

   assign xsq_full = in_item.x * in_item.x;
   assign y_val    = hist_rd_ff;
   assign y_eff    = r1_sub_ff ? y_val : '0;
   assign ysq_full = y_eff * y_eff;

   // newest sum for this dimension may be written on the same edge
   assign fwd_in  = adv_out && (r2_d_ff == r1_d_ff);
   assign zero_in = r1_start_ff || (adv_out && r2_start_ff) || !sum_vld_ff[r1_d_ff];

   always_comb begin
      old_sum = sum_rd_ff;
      old_sq  = sq_rd_ff;
      if (zero_ff) begin
         old_sum = '0;
         old_sq  = '0;
      end else if (fwd_ff) begin
         old_sum = fwd_sum_ff;
         old_sq  = fwd_sq_ff;
      end
      new_sum = old_sum + {{(SUM_W - SAMPLE_BITS){r2_x_ff[SAMPLE_BITS-1]}}, r2_x_ff}
                        - {{(SUM_W - SAMPLE_BITS){r2_y_ff[SAMPLE_BITS-1]}}, r2_y_ff};
      new_sq  = old_sq + SQ_W'(r2_xsq_ff) - SQ_W'(r2_ysq_ff);
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         hist_rd_ff               <= hist_mem[in_item.rd_addr];
         hist_mem[in_item.wr_addr] <= in_item.x;
         r1_x_ff                  <= in_item.x;
         r1_start_ff              <= in_item.start;
         r1_last_ff               <= in_item.last;
         r1_sub_ff                <= in_item.sub;
         r1_d_ff                  <= in_item.d;
         r1_frames_ff             <= in_item.frames;
         r1_xsq_ff                <= PROD_W'(xsq_full);
      end
      if (adv_r2) begin
         sum_rd_ff    <= sum_mem[r1_d_ff];
         sq_rd_ff     <= sq_mem[r1_d_ff];
         fwd_sum_ff   <= new_sum;
         fwd_sq_ff    <= new_sq;
         fwd_ff       <= !r1_start_ff && fwd_in;
         zero_ff      <= r1_start_ff || (!fwd_in && zero_in);
         r2_x_ff      <= r1_x_ff;
         r2_y_ff      <= y_eff;
         r2_start_ff  <= r1_start_ff;
         r2_last_ff   <= r1_last_ff;
         r2_d_ff      <= r1_d_ff;
         r2_frames_ff <= r1_frames_ff;
         r2_xsq_ff    <= r1_xsq_ff;
         r2_ysq_ff    <= PROD_W'(ysq_full);
      end
      if (adv_out) begin
         sum_mem[r2_d_ff]      <= new_sum;
         sq_mem[r2_d_ff]       <= new_sq;
         rsp_window_sum        <= new_sum;
         rsp_window_square_sum <= new_sq;
         rsp_frames_in_window  <= r2_frames_ff;
         rsp_dim_index         <= r2_d_ff;
         rsp_last_of_frame     <= r2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff  <= 1'b0;
         r2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_vld_ff   <= '0;
      end else begin
         if (pop) begin
            r1_valid_ff <= 1'b1;
         end else if (adv_r2) begin
            r1_valid_ff <= 1'b0;
         end
         if (adv_r2) begin
            r2_valid_ff <= 1'b1;
         end else if (adv_out) begin
            r2_valid_ff <= 1'b0;
         end
         if (adv_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (adv_out) begin
            if (r2_start_ff) begin
               sum_vld_ff <= MAX_DIM'(1) << r2_d_ff;
            end else begin
               sum_vld_ff[r2_d_ff] <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/sliding_window_feature_stats.sv -----
`timescale 1ns / 1ps
// Per-dimension sliding-window sum and sum of squares over a stream of Q8.8 feature
// elements, feat_dim elements per frame, window_len frames per window. One word is
// taken per clock while req_stall is low, and one result word is returned per input
// word; a result passes through the history memory read, sums memory read and output
// registers in turn, and a four-entry queue between the front classifier and the
// back lets each side stall on its own. A word with start_of_stream set clears the
// sums and counters; history memory contents survive and need no clearing.
// Registers are written through csr_ with index 0 window_len, index 1 feat_dim;
// the user must write them only while no words are in flight, as the block
// itself does not enforce it.
module sliding_window_feature_stats (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [swfs_pkg::CSR_AW-1:0]             csr_index,
   input  logic [swfs_pkg::CSR_W-1:0]              csr_wr_data,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [swfs_pkg::SAMPLE_BITS-1:0] req_feature_value,
   input  logic                                    req_start_of_stream,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [swfs_pkg::SUM_W-1:0]       rsp_window_sum,
   output logic [swfs_pkg::SQ_W-1:0]               rsp_window_square_sum,
   output logic [swfs_pkg::COUNT_W-1:0]            rsp_frames_in_window,
   output logic [swfs_pkg::DIM_W-1:0]              rsp_dim_index,
   output logic                                    rsp_last_of_frame
);
   import swfs_pkg::*;

   swfs_cfg_type  cfg_ff;
   swfs_item_type push_item, head_item;
   logic          q_push, q_full, q_pop, q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_len <= WIN_RESET;
         cfg_ff.feat_dim   <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_LEN: cfg_ff.window_len <= WIN_W'(csr_wr_data);
            CSR_FEAT_DIM:   cfg_ff.feat_dim   <= FD_W'(csr_wr_data);
            default: ;
         endcase
      end
   end

   swfs_front u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_feature_value   (req_feature_value),
      .req_start_of_stream (req_start_of_stream),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_item              (push_item)
   );

   swfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_item  (head_item)
   );

   swfs_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (q_valid),
      .in_item               (head_item),
      .pop                   (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_window_sum        (rsp_window_sum),
      .rsp_window_square_sum (rsp_window_square_sum),
      .rsp_frames_in_window  (rsp_frames_in_window),
      .rsp_dim_index         (rsp_dim_index),
      .rsp_last_of_frame     (rsp_last_of_frame)
   );

   a_frames_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frames_in_window != '0) &&
                    (rsp_frames_in_window <= COUNT_W'(MAX_WINDOW)))
      else $error("frame count out of range");

   a_top_dim_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_dim_index == DIM_W'(MAX_DIM - 1)) |-> rsp_last_of_frame)
      else $error("highest dimension not flagged last");

   a_queue_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

endmodule
